// ----- sv/tjr_pkg.sv -----
// Package for the TDoA Jacobian row block: item structs, state encodings and
// shared constants. No dependencies.
`default_nettype none
package tjr_pkg;

  localparam int TOWER_SLOTS_DEF = 4;
  localparam int COORD_BITS_DEF  = 32;
  localparam int FRAC_BITS       = 29;

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_COMPUTE = 1'b1;

  // One input item
  typedef struct packed {
    logic               func;
    logic [2:0]         tower_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } cmd_t;

  // One result item
  typedef struct packed {
    logic [4:0]         row_index;
    logic signed [31:0] grad_x;
    logic signed [31:0] grad_y;
    logic signed [31:0] grad_z;
    logic               zero_range;
    logic               last;
  } row_t;

  // Unit vector engine result, valid while done is high
  typedef struct packed {
    logic               done;
    logic               zero;
    logic signed [31:0] ux;
    logic signed [31:0] uy;
    logic signed [31:0] uz;
  } uv_res_t;

  typedef enum logic [2:0] {
    UV_IDLE, UV_NORM, UV_SQR, UV_SQRT, UV_DIV_LOAD, UV_DIV, UV_DONE
  } uv_state_t;

  typedef enum logic [2:0] {
    T_IDLE, T_START, T_WAIT, T_ROWA, T_ROWB, T_HOLD
  } top_state_t;

endpackage
`default_nettype wire

// ----- sv/tdoa_jacobian_rows_top.sv -----
// TDoA Jacobian row block top level: tower store, per-tower sequencing and
// row output register. Depends on tjr_pkg and tjr_unitvec.
// A load item (func 0) writes one in-range tower slot and gives no row.
// A compute item (func 1) runs the bit-serial unit vector engine once per
// tower, then emits one row per tower pair i<j in order i outer, j inner,
// with last set on the final row. Per tower the engine does setup and
// hand-over, normalising shifts (one bit per cycle), shift-add squaring,
// square root and division, or only setup and hand-over when the position
// coincides with the tower. Each row is held on the output until it is
// taken. The input is stalled for the whole of a compute item. A row whose
// position coincides with either tower has zero_range set and zero entries.
`default_nettype none
module tdoa_jacobian_rows_top
  import tjr_pkg::*;
#(
  parameter int TOWER_SLOTS = TOWER_SLOTS_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  output logic      cmd_stall,
  input  cmd_t      cmd,
  output logic      row_valid,
  input  wire logic row_stall,
  output row_t      row
);

  localparam int CW   = (COORD_BITS < 32) ? COORD_BITS : 32;
  localparam int MW   = CW + 1;
  localparam int TW   = $clog2(TOWER_SLOTS);
  localparam int ROWS = TOWER_SLOTS * (TOWER_SLOTS - 1) / 2;

  top_state_t state, state_next;

  logic signed [CW-1:0] tx [TOWER_SLOTS];
  logic signed [CW-1:0] ty [TOWER_SLOTS];
  logic signed [CW-1:0] tz [TOWER_SLOTS];
  logic signed [CW-1:0] px, py, pz;

  logic signed [31:0] ux [TOWER_SLOTS];
  logic signed [31:0] uy [TOWER_SLOTS];
  logic signed [31:0] uz [TOWER_SLOTS];
  logic [TOWER_SLOTS-1:0] zr;

  logic [TW-1:0] t, i, j, rd;
  logic [4:0]    k;
  logic signed [31:0] uix, uiy, uiz;
  logic          zi, zrow, row_last;
  logic          uv_start, accept;
  logic signed [MW-1:0] dx, dy, dz;
  uv_res_t       uv_res;

  assign accept = cmd_valid && !cmd_stall;

  // tower store, written by load items
  always_ff @(posedge clk) begin
    if (accept && cmd.func == FUNC_LOAD && {1'b0, cmd.tower_index} < 4'(TOWER_SLOTS)) begin
      tx[cmd.tower_index[TW-1:0]] <= cmd.pos_x[CW-1:0];
      ty[cmd.tower_index[TW-1:0]] <= cmd.pos_y[CW-1:0];
      tz[cmd.tower_index[TW-1:0]] <= cmd.pos_z[CW-1:0];
    end
  end

  // difference from position to current tower
  assign dx = MW'(tx[t]) - MW'(px);
  assign dy = MW'(ty[t]) - MW'(py);
  assign dz = MW'(tz[t]) - MW'(pz);

  tjr_unitvec #(.MAG_BITS(MW)) u_uv (
    .clk   (clk),
    .rst   (rst),
    .start (uv_start),
    .dx    (dx),
    .dy    (dy),
    .dz    (dz),
    .res   (uv_res)
  );

  assign rd       = (state == T_ROWA) ? i : j;
  assign zrow     = zi || zr[rd];
  assign row_last = (k == 5'(ROWS - 1));

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake
  always_comb begin
    state_next = state;
    cmd_stall  = (state != T_IDLE);
    uv_start   = (state == T_START);
    unique case (state)
      T_IDLE:  if (accept && cmd.func == FUNC_COMPUTE) state_next = T_START;
      T_START: state_next = T_WAIT;
      T_WAIT: begin
        if (uv_res.done) state_next = (t == TW'(TOWER_SLOTS - 1)) ? T_ROWA : T_START;
      end
      T_ROWA:  state_next = T_ROWB;
      T_ROWB:  state_next = T_HOLD;
      T_HOLD: begin
        if (!row_stall) state_next = row.last ? T_IDLE : T_ROWA;
      end
      default: state_next = T_IDLE;
    endcase
  end

  // control counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= 1'b0;
      t <= '0;
      i <= '0;
      j <= '0;
      k <= '0;
    end else begin
      case (state)
        T_IDLE: begin
          if (accept && cmd.func == FUNC_COMPUTE) begin
            t <= '0;
            i <= '0;
            j <= TW'(1);
            k <= '0;
          end
        end
        T_WAIT: begin
          if (uv_res.done) t <= t + TW'(1);
        end
        T_ROWB: row_valid <= 1'b1;
        T_HOLD: begin
          if (!row_stall) begin
            row_valid <= 1'b0;
            k <= k + 5'd1;
            if (j == TW'(TOWER_SLOTS - 1)) begin
              i <= i + TW'(1);
              j <= i + TW'(2);
            end else begin
              j <= j + TW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      px <= cmd.pos_x[CW-1:0];
      py <= cmd.pos_y[CW-1:0];
      pz <= cmd.pos_z[CW-1:0];
    end
    if (state == T_WAIT && uv_res.done) begin
      ux[t] <= uv_res.ux;
      uy[t] <= uv_res.uy;
      uz[t] <= uv_res.uz;
      zr[t] <= uv_res.zero;
    end
    if (state == T_ROWA) begin
      uix <= ux[rd];
      uiy <= uy[rd];
      uiz <= uz[rd];
      zi  <= zr[rd];
    end
    if (state == T_ROWB) begin
      row.row_index  <= k;
      row.grad_x     <= zrow ? '0 : uix - ux[rd];
      row.grad_y     <= zrow ? '0 : uiy - uy[rd];
      row.grad_z     <= zrow ? '0 : uiz - uz[rd];
      row.zero_range <= zrow;
      row.last       <= row_last;
    end
  end

  // a zero-range row carries zero entries
  a_zero_row: assert property (@(posedge clk) disable iff (rst)
    row_valid && row.zero_range |-> row.grad_x == 0 && row.grad_y == 0 && row.grad_z == 0)
    else $error("zero-range row with non-zero entries");

  // engine results arrive only while the sequencer waits for them
  a_uv_done: assert property (@(posedge clk) disable iff (rst)
    uv_res.done |-> state == T_WAIT)
    else $error("unit vector result outside wait state");

  // after the final row the block is idle again
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    row_valid && !row_stall && row.last |=> !row_valid && !cmd_stall)
    else $error("block not idle after final row");

endmodule
`default_nettype wire

// ----- sv/tjr_unitvec.sv -----
// Bit-serial unit vector engine: normalising shifter, shift-add squarer,
// restoring square root and restoring divider. Depends on tjr_pkg.
`default_nettype none
module tjr_unitvec
  import tjr_pkg::*;
#(
  parameter int MAG_BITS = COORD_BITS_DEF + 1
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic signed [MAG_BITS-1:0] dx,
  input  wire logic signed [MAG_BITS-1:0] dy,
  input  wire logic signed [MAG_BITS-1:0] dz,
  output uv_res_t                         res
);

  localparam int NW = (MAG_BITS > 31) ? MAG_BITS : 31;

  uv_state_t state, state_next;

  logic signed [MAG_BITS-1:0] din [3];
  logic [NW-1:0] mag_in [3];
  logic [NW-1:0] mag [3];
  logic [2:0]    neg;
  logic [1:0]    comp;
  logic [5:0]    cnt;
  logic          zero;
  logic [NW-1:0] m01, mmax;
  logic          all_zero;

  // squarer
  logic [61:0] mcand;
  logic [30:0] mplr;
  logic [63:0] acc;
  logic [30:0] mag_nxt;

  // square root
  logic [63:0] sqv;
  logic [31:0] root;
  logic [35:0] rem, rem_sh, trial;

  // divider
  logic [60:0] num;
  logic [31:0] drem;
  logic [30:0] dnum, quot;
  logic [32:0] dt, dsub;
  logic        qbit;
  logic [30:0] qfin;
  logic signed [31:0] u [3];

  assign din[0] = dx;
  assign din[1] = dy;
  assign din[2] = dz;

  // magnitudes of the incoming differences
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mag_in[c] = din[c][MAG_BITS-1] ? NW'($unsigned(-din[c])) : NW'($unsigned(din[c]));
    end
  end
  assign all_zero = (mag_in[0] == '0) && (mag_in[1] == '0) && (mag_in[2] == '0);

  // largest magnitude for normalising
  assign m01  = (mag[0] > mag[1]) ? mag[0] : mag[1];
  assign mmax = (m01 > mag[2]) ? m01 : mag[2];

  assign mag_nxt = (comp == 2'd0) ? mag[1][30:0] : mag[2][30:0];

  // root step
  assign rem_sh = {rem[33:0], sqv[63:62]};
  assign trial  = {2'b00, root, 2'b01};

  // divide step
  assign num  = {1'b0, mag[comp][30:0], {FRAC_BITS{1'b0}}} + 61'(root[31:1]);
  assign dt   = {drem, dnum[30]};
  assign dsub = dt - {1'b0, root};
  assign qbit = (dt >= {1'b0, root});
  assign qfin = {quot[29:0], qbit};

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= UV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      UV_IDLE:     if (start) state_next = all_zero ? UV_DONE : UV_NORM;
      UV_NORM:     if (((mmax >> 31) == '0) && mmax[30]) state_next = UV_SQR;
      UV_SQR:      if (cnt == 6'd30 && comp == 2'd2) state_next = UV_SQRT;
      UV_SQRT:     if (cnt == 6'd31) state_next = UV_DIV_LOAD;
      UV_DIV_LOAD: state_next = UV_DIV;
      UV_DIV: begin
        if (cnt == 6'd30) state_next = (comp == 2'd2) ? UV_DONE : UV_DIV_LOAD;
      end
      UV_DONE:     state_next = UV_IDLE;
      default:     state_next = UV_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      UV_IDLE: begin
        if (start) begin
          for (int c = 0; c < 3; c++) begin
            mag[c] <= mag_in[c];
            neg[c] <= din[c][MAG_BITS-1];
            u[c]   <= '0;
          end
          zero <= all_zero;
        end
      end
      UV_NORM: begin
        if ((mmax >> 31) != '0) begin
          for (int c = 0; c < 3; c++) mag[c] <= mag[c] >> 1;
        end else if (!mmax[30]) begin
          for (int c = 0; c < 3; c++) mag[c] <= mag[c] << 1;
        end else begin
          comp  <= 2'd0;
          cnt   <= '0;
          acc   <= '0;
          mcand <= 62'(mag[0][30:0]);
          mplr  <= mag[0][30:0];
        end
      end
      UV_SQR: begin
        if (mplr[0]) acc <= acc + 64'(mcand);
        if (cnt == 6'd30) begin
          cnt <= '0;
          if (comp == 2'd2) begin
            sqv  <= mplr[0] ? acc + 64'(mcand) : acc;
            root <= '0;
            rem  <= '0;
            comp <= 2'd0;
          end else begin
            comp  <= comp + 2'd1;
            mcand <= 62'(mag_nxt);
            mplr  <= mag_nxt;
          end
        end else begin
          cnt   <= cnt + 6'd1;
          mcand <= mcand << 1;
          mplr  <= mplr >> 1;
        end
      end
      UV_SQRT: begin
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[30:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[30:0], 1'b0};
        end
        sqv <= sqv << 2;
        cnt <= (cnt == 6'd31) ? '0 : cnt + 6'd1;
      end
      UV_DIV_LOAD: begin
        drem <= 32'(num[60:31]);
        dnum <= num[30:0];
        quot <= '0;
        cnt  <= '0;
      end
      UV_DIV: begin
        drem <= qbit ? dsub[31:0] : dt[31:0];
        dnum <= dnum << 1;
        quot <= qfin;
        cnt  <= cnt + 6'd1;
        if (cnt == 6'd30) begin
          u[comp] <= neg[comp] ? -$signed(32'(qfin)) : $signed(32'(qfin));
          if (comp != 2'd2) comp <= comp + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign res.done = (state == UV_DONE);
  assign res.zero = zero;
  assign res.ux   = u[0];
  assign res.uy   = u[1];
  assign res.uz   = u[2];

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for tdoa_jacobian_rows_top: loads tower positions,
// predicts unit-vector difference rows per compute item and checks every row.
// Depends on tjr_pkg and the block's RTL.
`timescale 1ns / 100ps
module testbench;
  import tjr_pkg::*;

  localparam int SLOTS     = TOWER_SLOTS_DEF;
  localparam int PAIRS     = SLOTS * (SLOTS - 1) / 2;
  localparam int MAX_DELAY = 18;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic row_valid;
  logic row_stall = 1'b0;
  row_t row;

  // Predictor copy of the tower store
  logic signed [31:0] twr_x [SLOTS];
  logic signed [31:0] twr_y [SLOTS];
  logic signed [31:0] twr_z [SLOTS];

  row_t rows_due [$];
  int   errors = 0;
  bit   hold_rows = 1'b0;
  bit   no_rx_gaps = 1'b0;
  bit   no_tx_gaps = 1'b0;

  tdoa_jacobian_rows_top u_dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .row_valid(row_valid), .row_stall(row_stall), .row(row)
  );

  always #1 clk = ~clk;

  initial begin
    #8000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Integer square root, floor
  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Unit vector from position to tower in Q2.29; returns 1 when zero range
  function automatic bit unit_towards(input longint dx, input longint dy,
                                      input longint dz, output longint u [3]);
    longint d [3];
    longint unsigned mag [3];
    longint unsigned m, s, r, q;
    d[0] = dx; d[1] = dy; d[2] = dz;
    m = 0;
    s = 0;
    for (int c = 0; c < 3; c++) begin
      mag[c] = (d[c] < 0) ? -d[c] : d[c];
      if (mag[c] > m) m = mag[c];
      u[c] = 0;
    end
    if (m == 0) return 1'b1;
    while (m >= (64'd1 << 31)) begin
      for (int c = 0; c < 3; c++) mag[c] = mag[c] >> 1;
      m = m >> 1;
    end
    while (m < (64'd1 << 30)) begin
      for (int c = 0; c < 3; c++) mag[c] = mag[c] << 1;
      m = m << 1;
    end
    for (int c = 0; c < 3; c++) s = s + mag[c] * mag[c];
    r = root_floor(s);
    for (int c = 0; c < 3; c++) begin
      q = ((mag[c] << FRAC_BITS) + (r >> 1)) / r;
      u[c] = (d[c] < 0) ? -longint'(q) : longint'(q);
    end
    return 1'b0;
  endfunction

  // Update store or queue the rows a compute item gives
  function automatic void predict_rows(input cmd_t c);
    longint u [SLOTS][3];
    longint t [3];
    bit zr [SLOTS];
    row_t r;
    int k;
    if (c.func == FUNC_LOAD) begin
      if (c.tower_index < SLOTS) begin
        twr_x[c.tower_index] = c.pos_x;
        twr_y[c.tower_index] = c.pos_y;
        twr_z[c.tower_index] = c.pos_z;
      end
      return;
    end
    for (int i = 0; i < SLOTS; i++) begin
      zr[i] = unit_towards(longint'(twr_x[i]) - longint'(c.pos_x),
                           longint'(twr_y[i]) - longint'(c.pos_y),
                           longint'(twr_z[i]) - longint'(c.pos_z), t);
      for (int e = 0; e < 3; e++) u[i][e] = t[e];
    end
    k = 0;
    for (int i = 0; i < SLOTS; i++)
      for (int j = i + 1; j < SLOTS; j++) begin
        r.row_index  = k[4:0];
        r.zero_range = zr[i] | zr[j];
        r.grad_x     = r.zero_range ? 32'sd0 : 32'(u[i][0] - u[j][0]);
        r.grad_y     = r.zero_range ? 32'sd0 : 32'(u[i][1] - u[j][1]);
        r.grad_z     = r.zero_range ? 32'sd0 : 32'(u[i][2] - u[j][2]);
        r.last       = (k == PAIRS - 1);
        rows_due.push_back(r);
        k++;
      end
  endfunction

  // Row checker
  always @(posedge clk) begin
    row_t exp_row;
    if (!rst && row_valid && !row_stall) begin
      if (rows_due.size() == 0) begin
        $display("%0t: unexpected row, actual %p", $time, row);
        errors++;
      end else begin
        exp_row = rows_due.pop_front();
        if (row !== exp_row) begin
          $display("%0t: row mismatch, expected %p actual %p", $time, exp_row, row);
          errors++;
        end
      end
    end
  end

  // Receiver stall pattern
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_rows) row_stall <= 1'b1;
      else if (row_valid && !row_stall) begin
        gap = no_rx_gaps ? 0 : $urandom_range(0, MAX_DELAY);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
          row_stall <= 1'b1;
          repeat (gap) @(posedge clk);
        end
        row_stall <= 1'b0;
      end else begin
        row_stall <= 1'b0;
      end
    end
  end

  // Send one item, waiting for acceptance; valid stays high for a follow-on
  task automatic send_item(input cmd_t c);
    int gap;
    gap = no_tx_gaps ? 0 : $urandom_range(0, MAX_DELAY);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (cmd_stall);
    predict_rows(c);
  endtask

  function automatic cmd_t load_item(input int slot, input logic signed [31:0] x,
                                     input logic signed [31:0] y,
                                     input logic signed [31:0] z);
    cmd_t c;
    c.func = FUNC_LOAD; c.tower_index = slot[2:0];
    c.pos_x = x; c.pos_y = y; c.pos_z = z;
    return c;
  endfunction

  function automatic cmd_t compute_item(input logic signed [31:0] x,
                                        input logic signed [31:0] y,
                                        input logic signed [31:0] z);
    cmd_t c;
    c.func = FUNC_COMPUTE; c.tower_index = 3'($urandom);
    c.pos_x = x; c.pos_y = y; c.pos_z = z;
    return c;
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return 32'($urandom_range(0, 2000)) - 32'sd1000;
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($urandom);
    endcase
  endfunction

  task automatic drain_rows();
    cmd_valid <= 1'b0;
    while (rows_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Extremes of coordinates, zero range, bad slot indexes
  task automatic test_directed();
    send_item(load_item(0, 32'sd0, 32'sd0, 32'sd0));
    send_item(load_item(1, 32'h7fffffff, 32'h80000000, 32'sd5));
    send_item(load_item(2, 32'h80000000, 32'h7fffffff, 32'h80000000));
    send_item(load_item(3, 32'sd1, -32'sd1, 32'h7fffffff));
    send_item(load_item(7, 32'sd9, 32'sd9, 32'sd9));
    send_item(load_item(4, -32'sd9, 32'sd9, 32'sd9));
    send_item(compute_item(32'sd0, 32'sd0, 32'sd0));
    send_item(compute_item(32'h7fffffff, 32'h80000000, 32'sd5));
    send_item(compute_item(32'h80000000, 32'h80000000, 32'h80000000));
    send_item(compute_item(32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    send_item(compute_item(32'sd1, 32'sd0, 32'sd0));
    send_item(load_item(2, 32'sd0, 32'sd0, 32'sd0));
    send_item(compute_item(32'sd0, 32'sd0, 32'sd0));
    send_item(compute_item(32'sd3, -32'sd4, 32'sd12));
    send_item(compute_item(32'hffffffff, 32'sd0, 32'sd1));
  endtask

  // Output held off long while the sender keeps offering
  task automatic test_backpressure();
    fork
      begin
        hold_rows = 1'b1;
        repeat (3000) @(posedge clk);
        hold_rows = 1'b0;
      end
      begin
        no_tx_gaps = 1'b1;
        for (int n = 0; n < 4; n++)
          send_item(compute_item(rand_coord(), rand_coord(), rand_coord()));
        cmd_valid <= 1'b0;
        no_tx_gaps = 1'b0;
      end
    join
    drain_rows();
  endtask

  // Random tower loads and positions, some runs with no idling
  task automatic test_random(input int count);
    cmd_t c;
    for (int n = 0; n < count; n++) begin
      no_rx_gaps = (n % 60) < 10;
      no_tx_gaps = no_rx_gaps;
      if ($urandom_range(0, 2) == 0)
        c = load_item($urandom_range(0, 7), rand_coord(), rand_coord(), rand_coord());
      else if ($urandom_range(0, 9) == 0)
        c = compute_item(twr_x[1], twr_y[1], twr_z[1]);
      else
        c = compute_item(rand_coord(), rand_coord(), rand_coord());
      send_item(c);
      if (n % 80 == 79) drain_rows();
    end
    no_rx_gaps = 1'b0;
    no_tx_gaps = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    drain_rows();
    test_backpressure();
    test_random(310);
    drain_rows();
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
